[design/sgts_pkg.sv]
// Package for the sorted glyph table search block.
// Holds field widths, action and status codes and parameter defaults.
// No dependencies.
package sgts_pkg;

   localparam int ACTION_W = 2;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 5;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int ERR_W    = 2;

   localparam int DEF_MAX_ENTRIES = 8192;
   localparam int DEF_GLYPH_BYTES = 32;
   localparam int RESULTS_CAP     = 32;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ERR_W-1:0]    err_type;

   localparam action_type ACT_LOAD   = 2'd0;
   localparam action_type ACT_COMMIT = 2'd1;
   localparam action_type ACT_LOOKUP = 2'd2;
   localparam action_type ACT_CLEAR  = 2'd3;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_ORDER     = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_EMPTY     = 3'd3;
   localparam status_type ST_NOT_FOUND = 3'd4;

   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_ORDER = 2'd1;
   localparam err_type ERR_FULL  = 2'd2;

endpackage

[design/sgts_if.sv]
// Request and response channel interfaces of the glyph table search block.
// Depends on sgts_pkg for field widths.
interface sgts_req_if import sgts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [KEY_W-1:0]    codepoint;
   logic [POS_W-1:0]    byte_index;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, action, codepoint, byte_index, data_byte, input ready);
   modport sink   (input valid, action, codepoint, byte_index, data_byte, output ready);
endinterface

interface sgts_rsp_if import sgts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   glyph_byte;
   logic [POS_W-1:0]    out_index;
   logic                last;

   modport source (output valid, status, glyph_byte, out_index, last, input ready);
   modport sink   (input valid, status, glyph_byte, out_index, last, output ready);
endinterface

[design/sorted_glyph_table_search.sv]
// Sorted glyph table search: load, commit, clear, binary search and bitmap readout.
// Load, commit and clear requests answer through the response state; a load that starts
// a record first passes through the zero-fill state, which clears the record one byte a cycle.
// A lookup searches in probes (up to 14 probes at 8192 entries, each a key read then
// a compare); a miss answers with a not-found status, a hit streams min(GLYPH_BYTES, 32) bytes.
// Reset is synchronous and active high; the memories are not cleared and need no sweep.
module sorted_glyph_table_search import sgts_pkg::*; #(
   parameter int MaxEntries = DEF_MAX_ENTRIES,
   parameter int GlyphBytes = DEF_GLYPH_BYTES
) (
   input logic        clock,
   input logic        reset,
   sgts_req_if.sink   req_chan,
   sgts_rsp_if.source rsp_chan
);

   // Derived sizes. CNT_W holds an entry count up to and including MaxEntries.
   localparam int CNT_W    = $clog2(MaxEntries + 1);
   localparam int KEY_AW   = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int BMP_D    = MaxEntries * GlyphBytes;
   localparam int BMP_AW   = (BMP_D > 1) ? $clog2(BMP_D) : 1;
   localparam int ZC_W     = (GlyphBytes > 1) ? $clog2(GlyphBytes) : 1;
   localparam int EMIT_N   = (GlyphBytes < RESULTS_CAP) ? GlyphBytes : RESULTS_CAP;
   localparam int EMIT_W   = $clog2(EMIT_N + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ZERO  = 3'd1;
   localparam logic [2:0] S_RESP  = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   err_type           load_err_ff, load_err_in;
   logic [CNT_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]  high_ff, high_in;
   logic [BMP_AW-1:0] next_base_ff, next_base_in;
   logic [BMP_AW-1:0] rec_base_ff, rec_base_in;
   logic [ZC_W-1:0]   zc_ff, zc_in;
   logic [EMIT_W-1:0] iss_ff, iss_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   status_type        stat_ff, stat_in;
   logic [BMP_AW-1:0] base_ff, base_in;
   logic [POS_W-1:0]  rd_idx_ff, rd_idx_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0] rsp_glyph_ff, rsp_glyph_in;
   logic [POS_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic              key_wr_en;
   logic [KEY_AW-1:0] key_wr_addr;
   logic              key_rd_en;
   logic [KEY_AW-1:0] key_rd_addr;
   logic [KEY_W-1:0]  key_rd_data;
   logic              bmp_wr_en;
   logic [BMP_AW-1:0] bmp_wr_addr;
   logic [BYTE_W-1:0] bmp_wr_data;
   logic              bmp_rd_en;
   logic [BMP_AW-1:0] bmp_rd_addr;
   logic [BYTE_W-1:0] bmp_rd_data;

   logic              req_fire;
   logic              slot_free;
   logic              consume;
   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid_next;
   logic              pos_in_range;
   err_type           err_new;
   status_type        commit_stat;

   sgts_ram #(
      .Width (KEY_W),
      .Depth (MaxEntries),
      .AddrW (KEY_AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_chan.codepoint),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   sgts_ram #(
      .Width (BYTE_W),
      .Depth (BMP_D),
      .AddrW (BMP_AW)
   ) u_bmp_ram (
      .clock   (clock),
      .wr_en   (bmp_wr_en),
      .wr_addr (bmp_wr_addr),
      .wr_data (bmp_wr_data),
      .rd_en   (bmp_rd_en),
      .rd_addr (bmp_rd_addr),
      .rd_data (bmp_rd_data)
   );

   // One request at a time is taken; the response register is separate, so a new
   // request is accepted while the previous response still waits to be taken.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign consume        = rd_pend_ff && slot_free;

   // Midpoint of the search window; the extra bit keeps the sum from wrapping.
   assign mid_sum      = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_next     = mid_sum[CNT_W:1];
   assign pos_in_range = ({27'b0, req_chan.byte_index} < 32'(GlyphBytes));

   assign commit_stat = (load_err_ff != ERR_NONE) ? {1'b0, load_err_ff} :
                        (loaded_ff == '0)         ? ST_EMPTY : ST_OK;

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      active_in     = active_ff;
      prev_key_in   = prev_key_ff;
      load_err_in   = load_err_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      next_base_in  = next_base_ff;
      rec_base_in   = rec_base_ff;
      zc_in         = zc_ff;
      iss_in        = iss_ff;
      rd_pend_in    = rd_pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      mid_in        = mid_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      stat_in       = stat_ff;
      base_in       = base_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      err_new       = load_err_ff;

      key_wr_en   = 1'b0;
      key_wr_addr = loaded_ff[KEY_AW-1:0];
      key_rd_en   = 1'b0;
      key_rd_addr = mid_next[KEY_AW-1:0];
      bmp_wr_en   = 1'b0;
      bmp_wr_addr = rec_base_ff + BMP_AW'(req_chan.byte_index);
      bmp_wr_data = req_chan.data_byte;
      bmp_rd_en   = 1'b0;
      bmp_rd_addr = base_ff + BMP_AW'(iss_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_LOAD: begin
                     // Any load empties the searchable table.
                     active_in = '0;
                     state_in  = S_RESP;
                     if (load_err_ff == ERR_NONE && pos_in_range) begin
                        if (req_chan.byte_index == '0) begin
                           if (loaded_ff >= CNT_W'(MaxEntries)) begin
                              err_new = ERR_FULL;
                           end else if (loaded_ff != '0 &&
                                        req_chan.codepoint <= prev_key_ff) begin
                              err_new = ERR_ORDER;
                           end else begin
                              // Start a record: store the key, then zero-fill its bytes.
                              key_wr_en    = 1'b1;
                              prev_key_in  = req_chan.codepoint;
                              loaded_in    = loaded_ff + 1'b1;
                              rec_base_in  = next_base_ff;
                              next_base_in = next_base_ff + BMP_AW'(GlyphBytes);
                              data_in      = req_chan.data_byte;
                              zc_in        = '0;
                              state_in     = S_ZERO;
                           end
                        end else if (loaded_ff != '0) begin
                           // A later byte of the newest record goes straight in.
                           bmp_wr_en = 1'b1;
                        end
                     end
                     load_err_in = err_new;
                     stat_in     = {1'b0, err_new};
                  end
                  ACT_COMMIT: begin
                     stat_in      = commit_stat;
                     active_in    = (commit_stat == ST_OK) ? loaded_ff : '0;
                     loaded_in    = '0;
                     prev_key_in  = '0;
                     load_err_in  = ERR_NONE;
                     next_base_in = '0;
                     rec_base_in  = '0;
                     state_in     = S_RESP;
                  end
                  ACT_LOOKUP: begin
                     key_in   = req_chan.codepoint;
                     low_in   = '0;
                     high_in  = active_ff;
                     state_in = S_PROBE;
                  end
                  default: begin
                     // Clear returns the load, table and search registers to their reset values.
                     loaded_in    = '0;
                     active_in    = '0;
                     prev_key_in  = '0;
                     load_err_in  = ERR_NONE;
                     low_in       = '0;
                     high_in      = '0;
                     next_base_in = '0;
                     rec_base_in  = '0;
                     stat_in      = ST_OK;
                     state_in     = S_RESP;
                  end
               endcase
            end
         end
         S_ZERO: begin
            // Byte zero receives the loaded data, the rest of the record is cleared.
            bmp_wr_en   = 1'b1;
            bmp_wr_addr = rec_base_ff + BMP_AW'(zc_ff);
            bmp_wr_data = (zc_ff == '0) ? data_ff : '0;
            zc_in       = zc_ff + 1'b1;
            if (zc_ff == ZC_W'(GlyphBytes - 1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_glyph_in  = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_PROBE: begin
            if (low_ff < high_ff) begin
               key_rd_en = 1'b1;
               mid_in    = mid_next;
               state_in  = S_CMP;
            end else begin
               stat_in  = ST_NOT_FOUND;
               state_in = S_RESP;
            end
         end
         S_CMP: begin
            if (key_rd_data < key_ff) begin
               low_in   = mid_ff + 1'b1;
               state_in = S_PROBE;
            end else if (key_rd_data > key_ff) begin
               high_in  = mid_ff;
               state_in = S_PROBE;
            end else begin
               base_in    = BMP_AW'(mid_ff * GlyphBytes);
               iss_in     = '0;
               rd_pend_in = 1'b0;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            // While bytes remain to be read, a new byte read is issued whenever the read register
            // is free or is being drained into the response register in this cycle.
            if (iss_ff < EMIT_W'(EMIT_N) && (!rd_pend_ff || consume)) begin
               bmp_rd_en  = 1'b1;
               iss_in     = iss_ff + 1'b1;
               rd_idx_in  = POS_W'(iss_ff);
               rd_pend_in = 1'b1;
            end else if (consume) begin
               rd_pend_in = 1'b0;
            end
            if (consume) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_glyph_in  = bmp_rd_data;
               rsp_index_in  = rd_idx_ff;
               rsp_last_in   = (rd_idx_ff == POS_W'(EMIT_N - 1));
               if (rd_idx_ff == POS_W'(EMIT_N - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         active_ff    <= '0;
         prev_key_ff  <= '0;
         load_err_ff  <= ERR_NONE;
         low_ff       <= '0;
         high_ff      <= '0;
         next_base_ff <= '0;
         rec_base_ff  <= '0;
         zc_ff        <= '0;
         iss_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         active_ff    <= active_in;
         prev_key_ff  <= prev_key_in;
         load_err_ff  <= load_err_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         next_base_ff <= next_base_in;
         rec_base_ff  <= rec_base_in;
         zc_ff        <= zc_in;
         iss_ff       <= iss_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      stat_ff       <= stat_in;
      base_ff       <= base_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_glyph_ff  <= rsp_glyph_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.glyph_byte = rsp_glyph_ff;
   assign rsp_chan.out_index  = rsp_index_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // A full error can only be raised with the load counter at capacity, and it
   // stays there until a commit or clear resets both.
   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      load_err_ff == ERR_FULL |-> loaded_ff == CNT_W'(MaxEntries))
      else $error("full error without a full load phase");

   // A committed table exists only between a commit and the next load or clear.
   a_active_clean: assert property (@(posedge clock) disable iff (reset)
      active_ff != '0 |-> (loaded_ff == '0 && load_err_ff == ERR_NONE))
      else $error("searchable table coexists with a load phase");

   // Error and miss responses are always single, so they carry the last mark.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_last_ff)
      else $error("error response without last mark");

   // No bitmap read may be left outstanding when the sequencer goes idle.
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && state_in == S_IDLE |=> !rd_pend_ff)
      else $error("bitmap read pending after readout");

endmodule

[design/sgts_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the key store and the bitmap store. No dependencies.
module sgts_ram #(
   parameter int Width = 8,
   parameter int Depth = 2,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // The read register holds its value while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
